// ===== rtl/core/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types and constants for the frame parser and its channels.
// ----------------------------------------------------------------------------
package wsd_pkg;

   localparam int unsigned LIMIT_W = 33;
   localparam int unsigned LEN_W   = 64;
   localparam int unsigned LEFT_W  = 4;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 33'd1048576;

   localparam logic [6:0] LEN16_CODE = 7'd126;
   localparam logic [6:0] LEN64_CODE = 7'd127;

   localparam logic [LEFT_W-1:0] LEN16_BYTES = 4'd2;
   localparam logic [LEFT_W-1:0] LEN64_BYTES = 4'd8;
   localparam logic [LEFT_W-1:0] KEY_BYTES   = 4'd4;

   localparam logic [3:0] OPC_CONT   = 4'd0;
   localparam logic [3:0] OPC_TEXT   = 4'd1;
   localparam logic [3:0] OPC_BINARY = 4'd2;
   localparam logic [3:0] OPC_CLOSE  = 4'd8;
   localparam logic [3:0] OPC_PING   = 4'd9;
   localparam logic [3:0] OPC_PONG   = 4'd10;

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      EV_PAYLOAD = 2'd0,
      EV_EMPTY   = 2'd1,
      EV_CLOSE   = 2'd2,
      EV_TOO_BIG = 2'd3
   } event_kind_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [7:0] payload_byte;
      logic [3:0] message_opcode;
      logic       message_last;
   } event_type;

endpackage

// ===== rtl/core/wsd_byte_if.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer byte channel
// Valid/ready channel carrying one received stream byte per word.
// ----------------------------------------------------------------------------
interface wsd_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/wsd_event_if.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer event channel
// Valid/ready channel carrying one parser event per word.
// ----------------------------------------------------------------------------
interface wsd_event_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_kind;
   logic [7:0] payload_byte;
   logic [3:0] message_opcode;
   logic       message_last;

   modport source (output valid, output event_kind, output payload_byte,
                   output message_opcode, output message_last, input ready);
   modport sink   (input valid, input event_kind, input payload_byte,
                   input message_opcode, input message_last, output ready);
endinterface

// ===== rtl/core/wsd_csr_if.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer register write channel
// Valid/ready channel carrying the frame size limit write data.
// ----------------------------------------------------------------------------
interface wsd_csr_if;
   logic        valid;
   logic        ready;
   logic [32:0] size_limit;

   modport source (output valid, output size_limit, input ready);
   modport sink   (input valid, input size_limit, output ready);
endinterface

// ===== rtl/core/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer parser
// Frame header state machine, length check and payload unmasking per byte.
// ----------------------------------------------------------------------------
module wsd_parser
   import wsd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         rx_byte,
   input  logic [LIMIT_W-1:0] limit,
   output logic               evt_valid,
   output event_type          evt
);

   phase_type          phase_ff, phase_in;
   logic               fin_ff, fin_in;
   logic               masked_ff, masked_in;
   logic [3:0]         frame_opc_ff, frame_opc_in;
   logic [LEN_W-1:0]   ext_len_ff, ext_len_in;
   logic [LEFT_W-1:0]  hdr_left_ff, hdr_left_in;
   logic [31:0]        mask_key_ff, mask_key_in;
   logic [LIMIT_W-1:0] payload_left_ff, payload_left_in;
   logic [1:0]         key_pos_ff, key_pos_in;
   logic [3:0]         cur_opc_ff, cur_opc_in;
   logic               halted_ff, halted_in;

   logic               is_ext_code;
   logic               hdr_done;
   logic               last_hdr_byte;
   logic [LEN_W-1:0]   len_now;
   logic               is_close;
   logic [3:0]         opc_applied;
   logic               too_big;
   logic               len_zero;
   logic               payload_end;
   logic [7:0]         key_byte;

   // header decode
   always_comb begin
      is_ext_code   = (rx_byte[6:0] == LEN16_CODE) || (rx_byte[6:0] == LEN64_CODE);
      last_hdr_byte = (hdr_left_ff == LEFT_W'(1));
      len_now       = ext_len_ff;
      hdr_done      = 1'b0;
      case (phase_ff)
         PH_HDR1: begin
            len_now  = {{(LEN_W-7){1'b0}}, rx_byte[6:0]};
            hdr_done = !is_ext_code && !rx_byte[7];
         end
         PH_EXTLEN: begin
            len_now  = {ext_len_ff[LEN_W-9:0], rx_byte};
            hdr_done = last_hdr_byte && !masked_ff;
         end
         PH_KEY: begin
            hdr_done = last_hdr_byte;
         end
         default: begin
            hdr_done = 1'b0;
         end
      endcase
      is_close = (frame_opc_ff == OPC_CLOSE);
      case (frame_opc_ff) inside
         OPC_TEXT, OPC_BINARY, OPC_CLOSE, OPC_PING, OPC_PONG: opc_applied = frame_opc_ff;
         default:                                             opc_applied = cur_opc_ff;
      endcase
      too_big     = len_now >= {{(LEN_W-LIMIT_W){1'b0}}, limit};
      len_zero    = (len_now == '0);
      payload_end = (payload_left_ff == LIMIT_W'(1));
      case (key_pos_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
      if (!masked_ff) begin
         key_byte = 8'h00;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_HDR0: begin
            phase_in = PH_HDR1;
         end
         PH_HDR1: begin
            if (is_ext_code) begin
               phase_in = PH_EXTLEN;
            end else if (rx_byte[7]) begin
               phase_in = PH_KEY;
            end else if (len_zero || is_close || too_big) begin
               phase_in = PH_HDR0;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_EXTLEN: begin
            if (!last_hdr_byte) begin
               phase_in = PH_EXTLEN;
            end else if (masked_ff) begin
               phase_in = PH_KEY;
            end else if (len_zero || is_close || too_big) begin
               phase_in = PH_HDR0;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_KEY: begin
            if (!last_hdr_byte) begin
               phase_in = PH_KEY;
            end else if (len_zero || is_close || too_big) begin
               phase_in = PH_HDR0;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            phase_in = payload_end ? PH_HDR0 : PH_PAYLOAD;
         end
         default: begin
            phase_in = PH_HDR0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      fin_in          = fin_ff;
      masked_in       = masked_ff;
      frame_opc_in    = frame_opc_ff;
      ext_len_in      = ext_len_ff;
      hdr_left_in     = hdr_left_ff;
      mask_key_in     = mask_key_ff;
      payload_left_in = payload_left_ff;
      key_pos_in      = key_pos_ff;
      cur_opc_in      = cur_opc_ff;
      halted_in       = halted_ff;
      case (phase_ff)
         PH_HDR0: begin
            fin_in       = rx_byte[7];
            frame_opc_in = rx_byte[3:0];
         end
         PH_HDR1: begin
            masked_in   = rx_byte[7];
            mask_key_in = '0;
            ext_len_in  = is_ext_code ? '0 : len_now;
            if (is_ext_code) begin
               hdr_left_in = (rx_byte[6:0] == LEN16_CODE) ? LEN16_BYTES : LEN64_BYTES;
            end else begin
               hdr_left_in = KEY_BYTES;
            end
         end
         PH_EXTLEN: begin
            ext_len_in  = len_now;
            hdr_left_in = last_hdr_byte ? KEY_BYTES : hdr_left_ff - LEFT_W'(1);
         end
         PH_KEY: begin
            mask_key_in = {mask_key_ff[23:0], rx_byte};
            hdr_left_in = hdr_left_ff - LEFT_W'(1);
         end
         PH_PAYLOAD: begin
            key_pos_in      = key_pos_ff + 2'd1;
            payload_left_in = payload_left_ff - LIMIT_W'(1);
         end
         default: begin
            key_pos_in = key_pos_ff;
         end
      endcase
      if (hdr_done) begin
         cur_opc_in      = opc_applied;
         halted_in       = is_close || too_big;
         key_pos_in      = 2'd0;
         payload_left_in = len_now[LIMIT_W-1:0];
      end
   end

   // event outputs
   always_comb begin
      evt_valid            = 1'b0;
      evt.event_kind       = EV_PAYLOAD;
      evt.payload_byte     = 8'h00;
      evt.message_opcode   = cur_opc_ff;
      evt.message_last     = 1'b0;
      if (!halted_ff) begin
         if (hdr_done) begin
            evt.message_opcode = opc_applied;
            if (is_close) begin
               evt_valid      = 1'b1;
               evt.event_kind = EV_CLOSE;
            end else if (too_big) begin
               evt_valid      = 1'b1;
               evt.event_kind = EV_TOO_BIG;
            end else if (len_zero && fin_ff) begin
               evt_valid        = 1'b1;
               evt.event_kind   = EV_EMPTY;
               evt.message_last = 1'b1;
            end
         end else if (phase_ff == PH_PAYLOAD) begin
            evt_valid        = 1'b1;
            evt.payload_byte = rx_byte ^ key_byte;
            evt.message_last = payload_end && fin_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HDR0;
         fin_ff          <= 1'b0;
         masked_ff       <= 1'b0;
         hdr_left_ff     <= '0;
         payload_left_ff <= '0;
         key_pos_ff      <= '0;
         cur_opc_ff      <= OPC_CONT;
         halted_ff       <= 1'b0;
      end else if (step && !halted_ff) begin
         phase_ff        <= phase_in;
         fin_ff          <= fin_in;
         masked_ff       <= masked_in;
         hdr_left_ff     <= hdr_left_in;
         payload_left_ff <= payload_left_in;
         key_pos_ff      <= key_pos_in;
         cur_opc_ff      <= cur_opc_in;
         halted_ff       <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && !halted_ff) begin
         frame_opc_ff <= frame_opc_in;
         ext_len_ff   <= ext_len_in;
         mask_key_ff  <= mask_key_in;
      end
   end

`ifndef ASSERT_OFF
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");

   a_no_event_when_halted: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !evt_valid)
      else $error("event produced while halted");

   a_payload_count_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (payload_left_ff != '0))
      else $error("payload phase with no bytes left");

   a_header_count_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_EXTLEN || phase_ff == PH_KEY) |-> (hdr_left_ff != '0))
      else $error("header byte phase with no bytes left");
`endif

endmodule

// ===== rtl/core/wsd_out_stage.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer result register
// Holds one event until the consumer takes it; frees when it is taken.
// ----------------------------------------------------------------------------
module wsd_out_stage
   import wsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      step,
   input  logic      evt_valid,
   input  event_type evt,
   output logic      out_free,
   wsd_event_if.source rsp_if
);

   logic      valid_ff, valid_in;
   event_type data_ff;

   assign out_free = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (out_free) begin
         valid_in = step && evt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && evt_valid) begin
         data_ff <= evt;
      end
   end

   assign rsp_if.valid          = valid_ff;
   assign rsp_if.event_kind     = data_ff.event_kind;
   assign rsp_if.payload_byte   = data_ff.payload_byte;
   assign rsp_if.message_opcode = data_ff.message_opcode;
   assign rsp_if.message_last   = data_ff.message_last;

endmodule

// ===== rtl/core/websocket_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer top level
// Parses a received byte stream into unmasked payload bytes and frame events.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle and sustains one byte per cycle while the
// result register drains. A byte is held in the input register; an event it
// yields is registered into the result register, which holds it until taken,
// stalling the input meanwhile. Header bytes produce no event, except that the
// last header byte of a close, too-big or zero-length final frame reports it;
// zero-length non-final frames produce no event. After a close frame or a
// frame at or above size_limit the block reports once and then consumes and
// drops every byte until reset. Write size_limit only while idle.
module websocket_frame_deframer_top
   import wsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   wsd_byte_if.sink    req_if,
   wsd_event_if.source rsp_if,
   wsd_csr_if.sink     csr_if
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic               step;
   logic               out_free;
   logic               evt_valid;
   event_type          evt;

   assign step          = in_valid_ff && out_free;
   assign req_if.ready  = !in_valid_ff || step;
   assign csr_if.ready  = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_if.ready) begin
         in_valid_in = req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         limit_ff    <= LIMIT_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_if.valid) begin
            limit_ff <= csr_if.size_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.rx_byte;
      end
   end

   wsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (in_byte_ff),
      .limit     (limit_ff),
      .evt_valid (evt_valid),
      .evt       (evt)
   );

   wsd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .evt_valid (evt_valid),
      .evt       (evt),
      .out_free  (out_free),
      .rsp_if    (rsp_if)
   );

endmodule
